>>> sv/tks_pkg.sv
// Shared types, sizes and compare functions for the top-k score keeper.
// No dependencies; every other file imports this package.
package tks_pkg;

	localparam int SLOTS      = 64;
	localparam int ID_BITS    = 32;
	localparam int SCORE_BITS = 32;

	localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W     = $clog2(SLOTS + 1);
	localparam int CFG_W     = 7;
	localparam int CFG_RESET = 64;
	localparam int RANK_W    = 6;
	localparam int ACT_W     = 2;

	localparam int IN_W      = ((ID_BITS + SCORE_BITS + 7) / 8) * 8;
	localparam int OUT_RAW_W = RANK_W + ID_BITS + SCORE_BITS;
	localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

	typedef enum logic [ACT_W-1:0] {
		ACT_OFFER = 2'd0,
		ACT_DRAIN = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	typedef struct packed {
		logic [ID_BITS-1:0]           id;
		logic signed [SCORE_BITS-1:0] score;
	} kv_t;

	typedef struct packed {
		logic v;
		kv_t  kv;
	} entry_t;

	typedef struct packed {
		logic clr;
		logic step;
		logic shift;
	} cell_ctrl_t;

	function automatic logic ranks_above(entry_t a, entry_t b);
		logic gt;
		logic eq;
		gt = $signed(a.kv.score) > $signed(b.kv.score);
		eq = $signed(a.kv.score) == $signed(b.kv.score);
		return a.v && (!b.v || gt || (eq && (a.kv.id > b.kv.id)));
	endfunction

	function automatic logic kv_less(kv_t a, kv_t b);
		logic lt;
		logic eq;
		lt = $signed(a.score) < $signed(b.score);
		eq = $signed(a.score) == $signed(b.score);
		return lt || (eq && (a.id < b.id));
	endfunction

endpackage

>>> sv/top_k_score_keeper.sv
// Top-k score keeper: slot table, offer scan, drain through a sorting chain of cells.
// Depends on tks_pkg, tks_slot_store and tks_cell.
//
//  channel  | direction | handshake          | payload
//  s_*      | in        | s_tvalid/s_tready  | tuser: action; tdata: doc_id, score
//  m_*      | out       | m_tvalid/m_tready  | tdata: rank, out_doc_id, out_score; tlast
//  cfg_*    | in        | cfg_we             | cfg_wdata: slots_in_use
//
// One item at a time; n is the active slot count. Offer: one table read per slot,
// then the write state; an offer with id 0 or score at or below zero is dropped
// without a scan. Drain: n reads load the chain, the chain settles, then one result
// per cycle as m_tready allows. Clear and unused actions go straight back to idle.
// After reset the table is empty and slots_in_use is 64; no clearing pass.
// A stalled output holds the chain; the input waits until the chain is empty.
module top_k_score_keeper import tks_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // doc_id, score
	input  logic [ACT_W-1:0] s_tuser,   // action
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // rank, out_doc_id, out_score, zero pad
	output logic             m_tlast,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	typedef enum logic [6:0] {
		ST_IDLE       = 7'b0000001,
		ST_OFFER_RD   = 7'b0000010,
		ST_OFFER_WAIT = 7'b0000100,
		ST_OFFER_WR   = 7'b0001000,
		ST_DRAIN_RD   = 7'b0010000,
		ST_SETTLE     = 7'b0100000,
		ST_SHIFT      = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [CFG_W-1:0]  cfg_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  n_sat;
	kv_t               offer_q;
	logic [SLOT_W-1:0] addr_q;
	logic              rd_v_s1;
	logic [SLOT_W-1:0] rd_idx_s1;
	kv_t               rd_kv;
	kv_t               min_kv_q;
	logic [SLOT_W-1:0] min_idx_q;
	logic              match_q;
	logic [SLOT_W-1:0] match_idx_q;
	logic [CNT_W-1:0]  settle_q;
	logic [CNT_W-1:0]  emit_q;
	kv_t               out_kv_q;
	logic [RANK_W-1:0] rank_q;
	logic              last_q;
	logic              m_valid_q;

	action_t           act;
	kv_t               in_kv;
	logic              s_fire;
	logic              issue;
	logic              rd_last;
	logic              load_out;
	logic              emit_last;
	logic              scanning;
	logic              wr_en;
	cell_ctrl_t        ctrl;
	entry_t            feed;
	entry_t            held [SLOTS];
	entry_t            pass [SLOTS];

	assign act       = action_t'(s_tuser);
	assign in_kv.id  = s_tdata[ID_BITS-1:0];
	assign in_kv.score = s_tdata[ID_BITS+SCORE_BITS-1:ID_BITS];
	assign s_tready  = (state_q == ST_IDLE);
	assign s_fire    = s_tvalid && s_tready;

	assign n_sat = (cfg_q == '0) ? CNT_W'(1) :
		(cfg_q > CFG_W'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(cfg_q);

	assign issue     = (state_q == ST_OFFER_RD) || (state_q == ST_DRAIN_RD);
	assign rd_last   = CNT_W'(addr_q) == (n_q - CNT_W'(1));
	assign scanning  = (state_q == ST_OFFER_RD) || (state_q == ST_OFFER_WAIT);
	assign load_out  = (state_q == ST_SHIFT) && (!m_valid_q || m_tready);
	assign emit_last = emit_q == (n_q - CNT_W'(1));
	assign wr_en     = (state_q == ST_OFFER_WR) &&
		!($signed(offer_q.score) < $signed(min_kv_q.score));

	assign ctrl.clr   = s_fire && (act == ACT_DRAIN);
	assign ctrl.step  = (state_q == ST_DRAIN_RD) || (state_q == ST_SETTLE);
	assign ctrl.shift = load_out;

	assign feed.v  = rd_v_s1 && ctrl.step;
	assign feed.kv = rd_kv;

	tks_slot_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (s_fire && (act == ACT_CLEAR)),
		.wr_en   (wr_en),
		.wr_addr (match_q ? match_idx_q : min_idx_q),
		.wr_kv   (offer_q),
		.rd_en   (issue),
		.rd_addr (addr_q),
		.rd_kv   (rd_kv)
	);

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		entry_t cin;
		entry_t cnb;
		if (i == 0) begin : g_head
			assign cin = feed;
		end else begin : g_body
			assign cin = pass[i-1];
		end
		if (i == SLOTS - 1) begin : g_tail
			assign cnb = '0;
		end else begin : g_inner
			assign cnb = held[i+1];
		end
		tks_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.in_e   (cin),
			.nb_e   (cnb),
			.held   (held[i]),
			.pass   (pass[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cfg_q       <= CFG_W'(CFG_RESET);
			n_q         <= '0;
			offer_q     <= '0;
			addr_q      <= '0;
			rd_v_s1     <= 1'b0;
			rd_idx_s1   <= '0;
			min_kv_q    <= '0;
			min_idx_q   <= '0;
			match_q     <= 1'b0;
			match_idx_q <= '0;
			settle_q    <= '0;
			emit_q      <= '0;
			out_kv_q    <= '0;
			rank_q      <= '0;
			last_q      <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			rd_v_s1   <= issue;
			rd_idx_s1 <= addr_q;

			m_valid_q <= load_out || (m_valid_q && !m_tready);
			if (load_out) begin
				out_kv_q  <= held[0].kv;
				rank_q    <= RANK_W'(emit_q);
				last_q    <= emit_last;
			end

			if (rd_v_s1 && scanning) begin
				if ((rd_idx_s1 == '0) || kv_less(rd_kv, min_kv_q)) begin
					min_kv_q  <= rd_kv;
					min_idx_q <= rd_idx_s1;
				end
				if (!match_q && (rd_kv.id == offer_q.id)) begin
					match_q     <= 1'b1;
					match_idx_q <= rd_idx_s1;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						n_q      <= n_sat;
						offer_q  <= in_kv;
						addr_q   <= '0;
						match_q  <= 1'b0;
						settle_q <= '0;
						emit_q   <= '0;
						case (act)
							ACT_OFFER: begin
								if ((in_kv.id != '0) && ($signed(in_kv.score) > 0)) begin
									state_q <= ST_OFFER_RD;
								end
							end
							ACT_DRAIN: begin
								state_q <= ST_DRAIN_RD;
							end
							default: ;
						endcase
					end
				end
				ST_OFFER_RD: begin
					addr_q <= addr_q + SLOT_W'(1);
					if (rd_last) begin
						state_q <= ST_OFFER_WAIT;
					end
				end
				ST_OFFER_WAIT: begin
					state_q <= ST_OFFER_WR;
				end
				ST_OFFER_WR: begin
					state_q <= ST_IDLE;
				end
				ST_DRAIN_RD: begin
					addr_q <= addr_q + SLOT_W'(1);
					if (rd_last) begin
						state_q <= ST_SETTLE;
					end
				end
				ST_SETTLE: begin
					settle_q <= settle_q + CNT_W'(1);
					if (settle_q == CNT_W'(SLOTS)) begin
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					if (load_out) begin
						emit_q <= emit_q + CNT_W'(1);
						if (emit_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_W'({out_kv_q.score, out_kv_q.id, rank_q});
	assign m_tlast  = last_q;

endmodule

>>> sv/tks_slot_store.sv
// Slot table: one write port, one registered read port, per-slot valid bits.
// An entry that is not valid reads as an empty slot. Depends on tks_pkg.
module tks_slot_store import tks_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clr,
	input  logic              wr_en,
	input  logic [SLOT_W-1:0] wr_addr,
	input  kv_t               wr_kv,
	input  logic              rd_en,
	input  logic [SLOT_W-1:0] rd_addr,
	output kv_t               rd_kv
);

	kv_t              mem [SLOTS];
	kv_t              rd_q;
	logic             rd_vld_q;
	logic [SLOTS-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_kv;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (clr) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_kv = rd_vld_q ? rd_q : '0;

endmodule

>>> sv/tks_cell.sv
// One cell of the sorting chain: keeps the better of its entry and the
// arriving one, passes the other on; shifts toward the head on output. Depends on tks_pkg.
module tks_cell import tks_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  entry_t     in_e,
	input  entry_t     nb_e,
	output entry_t     held,
	output entry_t     pass
);

	entry_t held_q;
	entry_t pass_q;
	logic   in_wins;

	assign in_wins = ranks_above(in_e, held_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			pass_q <= '0;
		end else if (ctrl.clr) begin
			held_q <= '0;
			pass_q <= '0;
		end else if (ctrl.shift) begin
			held_q <= nb_e;
			pass_q <= '0;
		end else if (ctrl.step) begin
			held_q <= in_wins ? in_e : held_q;
			pass_q <= in_wins ? held_q : in_e;
		end
	end

	assign held = held_q;
	assign pass = pass_q;

endmodule

>>> tb/top_k_score_keeper_tb.sv
// Self-checking bench for top_k_score_keeper: offers, drains, clears and slot-count writes.
// Holds its own copy of the slot table and checks each ranked item against it.
// Depends on tks_pkg and the top_k_score_keeper RTL.
module top_k_score_keeper_tb import tks_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = SLOTS + 16;
	localparam int MAX_REPORTS    = 10;

	typedef struct {
		logic [RANK_W-1:0]            rank;
		logic [ID_BITS-1:0]           id;
		logic signed [SCORE_BITS-1:0] score;
		logic                         last;
	} ranked_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;   // doc_id, score
	logic [ACT_W-1:0] s_tuser = '0;   // action
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;        // rank, out_doc_id, out_score, zero pad
	logic             m_tlast;
	logic             cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	logic [ID_BITS-1:0]           held_id [SLOTS];
	logic signed [SCORE_BITS-1:0] held_score [SLOTS];
	logic signed [SCORE_BITS-1:0] floor_score;
	int                           floor_slot;
	logic [CFG_W-1:0]             slots_reg;
	ranked_t                      pending_ranks [$];

	bit quiet = 1'b0;
	int hold_req = 0;
	int errors = 0;
	int items_sent = 0;
	int offers_sent = 0;
	int drains_sent = 0;
	int results_checked = 0;
	int settings_written = 0;

	top_k_score_keeper DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int active_slots();
		if (slots_reg == 0) return 1;
		if (slots_reg > SLOTS) return SLOTS;
		return int'(slots_reg);
	endfunction

	function automatic void refresh_floor();
		int n;
		int m;
		n = active_slots();
		m = 0;
		for (int i = 1; i < n; i++) begin
			if (held_score[i] < held_score[m] ||
			    (held_score[i] == held_score[m] && held_id[i] < held_id[m]))
				m = i;
		end
		floor_slot = m;
		floor_score = held_score[m];
	endfunction

	function automatic void empty_table();
		for (int i = 0; i < SLOTS; i++) begin
			held_id[i] = '0;
			held_score[i] = '0;
		end
		floor_score = '0;
		floor_slot = 0;
	endfunction

	function automatic bit sorts_above(int a, int b);
		if (held_score[a] != held_score[b]) return held_score[a] > held_score[b];
		return held_id[a] > held_id[b];
	endfunction

	function automatic void keeper_apply(logic [ACT_W-1:0] act, logic [ID_BITS-1:0] id,
	                                     logic signed [SCORE_BITS-1:0] score);
		ranked_t row [SLOTS];
		int n;
		int target;
		int r;
		bit found;
		n = active_slots();
		if (act == ACT_OFFER) begin
			if (id != 0 && score > 0 && score >= floor_score) begin
				target = (floor_slot < n) ? floor_slot : 0;
				found = 1'b0;
				for (int i = 0; i < n; i++) begin
					if (!found && held_id[i] == id) begin
						target = i;
						found = 1'b1;
					end
				end
				held_id[target] = id;
				held_score[target] = score;
				refresh_floor();
			end
		end else if (act == ACT_DRAIN) begin
			for (int i = 0; i < n; i++) begin
				r = 0;
				for (int j = 0; j < n; j++) begin
					if (sorts_above(j, i))
						r++;
					else if (j < i && held_id[j] == held_id[i] && held_score[j] == held_score[i])
						r++;
				end
				if (r >= n) r = n - 1;
				row[r].rank = RANK_W'(r);
				row[r].id = held_id[i];
				row[r].score = held_score[i];
				row[r].last = (r == n - 1);
			end
			for (int i = 0; i < n; i++) pending_ranks.push_back(row[i]);
		end else if (act == ACT_CLEAR) begin
			empty_table();
		end
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [ID_BITS-1:0] rand_id(int pool);
		int r;
		logic [ID_BITS-1:0] v;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			v = ID_BITS'($urandom_range(1, pool));
		end else if (r < 88) begin
			v = $urandom;
			if (v == 0) v = 1;
		end else begin
			v = {ID_BITS{1'b1}} - ID_BITS'($urandom_range(0, pool));
		end
		return v;
	endfunction

	function automatic logic signed [SCORE_BITS-1:0] rand_score();
		int r;
		logic signed [SCORE_BITS-1:0] v;
		r = $urandom_range(0, 99);
		if (r < 75) begin
			v = SCORE_BITS'($urandom_range(1, 48));
		end else if (r < 92) begin
			v = $urandom;
			v[SCORE_BITS-1] = 1'b0;
			if (v == 0) v = 1;
		end else begin
			v = {1'b0, {(SCORE_BITS-1){1'b1}}} - SCORE_BITS'($urandom_range(0, 3));
		end
		return v;
	endfunction

	task automatic send_item(input logic [ACT_W-1:0] act, input logic [ID_BITS-1:0] id,
	                         input logic signed [SCORE_BITS-1:0] score);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {score, id};
		do @(posedge clk); while (s_tready !== 1'b1);
		keeper_apply(act, id, score);
		items_sent++;
		if (act == ACT_OFFER) offers_sent++;
		if (act == ACT_DRAIN) drains_sent++;
	endtask

	task automatic wait_results_done();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_ranks.size() != 0);
	endtask

	task automatic write_slots(input logic [CFG_W-1:0] value);
		wait_results_done();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		slots_reg = value;
		refresh_floor();
		settings_written++;
	endtask

	task automatic check_result();
		ranked_t want;
		logic [RANK_W-1:0]            got_rank;
		logic [ID_BITS-1:0]           got_id;
		logic signed [SCORE_BITS-1:0] got_score;
		got_rank = m_tdata[RANK_W-1:0];
		got_id = m_tdata[RANK_W +: ID_BITS];
		got_score = m_tdata[RANK_W + ID_BITS +: SCORE_BITS];
		results_checked++;
		if (pending_ranks.size() == 0) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("unexpected item: rank %0d id %h score %h last %b",
				         got_rank, got_id, got_score, m_tlast);
		end else begin
			want = pending_ranks.pop_front();
			if (got_rank !== want.rank || got_id !== want.id ||
			    got_score !== want.score || m_tlast !== want.last) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("mismatch rank/id/score/last: exp %0d/%h/%h/%b got %0d/%h/%h/%b",
					         want.rank, want.id, want.score, want.last,
					         got_rank, got_id, got_score, m_tlast);
			end
		end
	endtask

	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid === 1'b1 && m_tready === 1'b1) check_result();
			if (hold_req > 0) begin
				stall_left = hold_req;
				hold_req = 0;
			end
			if (stall_left == 0 && $urandom_range(0, 2) == 0) stall_left = pick_gap();
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid === 1'b1 && s_tready === 1'b1) ||
			    (m_tvalid === 1'b1 && m_tready === 1'b1) || cfg_we === 1'b1)
				idle = 0;
			else
				idle++;
		end
		$display("watchdog: nothing moved for %0d cycles, %0d items still expected",
		         WATCHDOG_LIMIT, pending_ranks.size());
		$display("top_k_score_keeper_tb: FAIL");
		$finish;
	end

	task automatic test_field_extremes();
		send_item(ACT_OFFER, 32'hFFFF_FFFF, 32'sh7FFF_FFFF);
		send_item(ACT_OFFER, 32'h0000_0001, 32'sh0000_0001);
		send_item(ACT_OFFER, 32'h0000_0000, 32'sh0000_0064);
		send_item(ACT_OFFER, 32'h0000_0005, 32'sh0000_0000);
		send_item(ACT_OFFER, 32'h0000_0006, 32'sh8000_0000);
		send_item(ACT_OFFER, 32'h0000_0007, 32'shFFFF_FFFF);
		send_item(ACT_OFFER, 32'h0000_0001, 32'sh0001_8000);
		send_item(ACT_OFFER, 32'hAAAA_AAAA, 32'sh5555_5555);
		send_item(ACT_OFFER, 32'h5555_5555, 32'sh2AAA_AAAA);
		send_item(ACT_SPARE, $urandom, $urandom);
		send_item(ACT_DRAIN, '0, '0);
		send_item(ACT_CLEAR, $urandom, $urandom);
		send_item(ACT_DRAIN, '0, '0);
	endtask

	task automatic test_slot_register();
		write_slots(7'd0);
		send_item(ACT_OFFER, 32'd10, 32'sd5);
		send_item(ACT_OFFER, 32'd11, 32'sd5);
		send_item(ACT_OFFER, 32'd9, 32'sd4);
		send_item(ACT_DRAIN, '0, '0);
		write_slots(7'd127);
		send_item(ACT_OFFER, 32'd20, 32'sd7);
		send_item(ACT_OFFER, 32'd21, 32'sd9);
		send_item(ACT_OFFER, 32'd22, 32'sd3);
		write_slots(7'd2);
		send_item(ACT_OFFER, 32'd21, 32'sd50);
		send_item(ACT_OFFER, 32'd30, 32'sd100);
		send_item(ACT_DRAIN, '0, '0);
		write_slots(7'd64);
		send_item(ACT_DRAIN, '0, '0);
		send_item(ACT_CLEAR, '0, '0);
	endtask

	task automatic test_random_phase(input int slots, input int count, input bit calm);
		int r;
		write_slots(CFG_W'(slots));
		quiet = calm;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			if (r < 84)
				send_item(ACT_OFFER, rand_id(2 * slots + 4), rand_score());
			else if (r < 92)
				send_item(ACT_DRAIN, $urandom, $urandom);
			else if (r < 95)
				send_item(ACT_CLEAR, $urandom, $urandom);
			else if (r < 97)
				send_item(ACT_SPARE, $urandom, $urandom);
			else if (r < 98)
				send_item(ACT_OFFER, '0, rand_score());
			else
				send_item(ACT_OFFER, rand_id(2 * slots + 4),
				          -$signed(SCORE_BITS'($urandom_range(0, 1000))));
		end
		send_item(ACT_DRAIN, '0, '0);
		quiet = 1'b0;
	endtask

	task automatic test_output_backpressure();
		write_slots(7'd16);
		for (int k = 0; k < 20; k++) send_item(ACT_OFFER, rand_id(36), rand_score());
		hold_req = 400;
		send_item(ACT_DRAIN, '0, '0);
		for (int k = 0; k < 10; k++) send_item(ACT_OFFER, rand_id(36), rand_score());
		send_item(ACT_DRAIN, '0, '0);
		send_item(ACT_CLEAR, '0, '0);
	endtask

	task automatic test_pause_for_results();
		write_slots(7'd8);
		for (int k = 0; k < 15; k++) send_item(ACT_OFFER, rand_id(20), rand_score());
		send_item(ACT_DRAIN, '0, '0);
		wait_results_done();
		for (int k = 0; k < 15; k++) send_item(ACT_OFFER, rand_id(20), rand_score());
		send_item(ACT_DRAIN, '0, '0);
	endtask

	initial begin
		slots_reg = CFG_W'(CFG_RESET);
		empty_table();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_field_extremes();
		test_slot_register();
		test_random_phase(4, 90, 1'b0);
		test_random_phase(8, 80, 1'b1);
		test_random_phase(16, 70, 1'b0);
		test_random_phase(1, 35, 1'b0);
		test_random_phase(64, 40, 1'b0);
		test_random_phase(3, 55, 1'b1);
		test_output_backpressure();
		test_pause_for_results();
		wait_results_done();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d items (%0d offers, %0d drains) and %0d ranked items checked",
		         items_sent, offers_sent, drains_sent, results_checked);
		$display("over %0d slot-count writes from 0 to 127, %0d mismatches",
		         settings_written, errors);
		if (errors == 0 && pending_ranks.size() == 0)
			$display("top_k_score_keeper_tb: PASS");
		else
			$display("top_k_score_keeper_tb: FAIL");
		$finish;
	end

endmodule
